[src/window_median_filter_macros.svh]
// Assertion macros shared by the median filter modules.
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH
`ifndef SYNTH
`define WMF_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define WMF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WMF_CHECK(lbl, cond, msg)
`define WMF_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/wmf_pkg.sv]
// Types and constants of the window median filter.
package wmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 5;
  localparam int MAX_HEIGHT = 4096;
  localparam int HALF_MAX   = MAX_WINDOW / 2;

  localparam int DATA_W     = 32;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int WIN_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int HALF_W     = $clog2(HALF_MAX + 1);
  localparam int NUM_BANKS  = MAX_WINDOW * MAX_WINDOW;
  localparam int BANK_W     = $clog2(NUM_BANKS);
  localparam int BANK_DEPTH = (MAX_WIDTH + MAX_WINDOW - 1) / MAX_WINDOW;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int MAX_LAG    = HALF_MAX * MAX_WIDTH + HALF_MAX;
  localparam int PEND_W     = $clog2(MAX_LAG + 2);

  // a result holds its credit from input transfer to output transfer
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd3;

  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [WIN_W-1:0]   RST_WINDOW       = 3'd3;

  typedef struct packed {
    logic                 we;
    logic [BANK_W-1:0]    bank;
    logic [BANK_AW-1:0]   addr;
    logic [DATA_W-1:0]    data;
  } wmf_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [NUM_BANKS-1:0] mask;
    logic [BANK_W-1:0]    centre;
    logic [BANK_W-1:0]    target;
    logic                 inwin;
    logic                 last;
  } wmf_meta_t;

  typedef logic [MAX_WINDOW-1:0][BANK_AW-1:0] wmf_col_addr_t;
  typedef logic [NUM_BANKS-1:0][DATA_W-1:0]   wmf_window_t;

endpackage

[src/wmf_ram.sv]
// One line-store bank: one write and one registered read port, write-through on collision.
module wmf_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [wmf_pkg::BANK_AW-1:0] waddr,
  input  logic [wmf_pkg::DATA_W-1:0]  wdata,
  input  logic [wmf_pkg::BANK_AW-1:0] raddr,
  output logic [wmf_pkg::DATA_W-1:0]  rdata
);

  logic [wmf_pkg::DATA_W-1:0] mem [wmf_pkg::BANK_DEPTH];
  logic [wmf_pkg::DATA_W-1:0] rd_r;
  logic [wmf_pkg::DATA_W-1:0] wd_r;
  logic                       fwd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r  <= mem[raddr];
    wd_r  <= wdata;
    fwd_r <= we && (waddr == raddr);
  end

  assign rdata = fwd_r ? wd_r : rd_r;

endmodule

[src/wmf_ctrl.sv]
// Configuration registers, raster positions, lag count and window addressing.
`include "window_median_filter_macros.svh"
module wmf_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           acc,
  input  logic                           func,
  input  logic [wmf_pkg::DATA_W-1:0]     sample,
  output wmf_pkg::wmf_wr_t               wr,
  output wmf_pkg::wmf_meta_t             meta,
  output wmf_pkg::wmf_col_addr_t         col_addr
);

  localparam int MW = wmf_pkg::MAX_WINDOW;
  localparam int HM = wmf_pkg::HALF_MAX;

  logic [wmf_pkg::IMG_W_W-1:0] img_w_r;
  logic [wmf_pkg::IMG_H_W-1:0] img_h_r;
  logic [wmf_pkg::WIN_W-1:0]   win_w_r, win_h_r;

  logic [wmf_pkg::COL_W-1:0]   in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [wmf_pkg::BANK_AW-1:0] in_q_r, in_q_nxt, out_q_r, out_q_nxt;
  logic [wmf_pkg::SLOT_W-1:0]  in_m_r, in_m_nxt, out_m_r, out_m_nxt;
  logic [wmf_pkg::ROW_W-1:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [wmf_pkg::SLOT_W-1:0]  in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [wmf_pkg::PEND_W-1:0]  pending_r, pending_nxt;

  logic [wmf_pkg::IMG_W_W-1:0] w;
  logic [wmf_pkg::IMG_H_W-1:0] h;
  logic [wmf_pkg::HALF_W-1:0]  hx, hy;
  logic [wmf_pkg::PEND_W-1:0]  d;
  logic                        pixel, emit;
  logic [MW-1:0]               colmask, rowmask;
  logic [wmf_pkg::BANK_W-1:0]  n_win;

  // effective sizes
  always_comb begin
    if (img_w_r == '0) begin
      w = wmf_pkg::IMG_W_W'(1);
    end else if (img_w_r > wmf_pkg::IMG_W_W'(wmf_pkg::MAX_WIDTH)) begin
      w = wmf_pkg::IMG_W_W'(wmf_pkg::MAX_WIDTH);
    end else begin
      w = img_w_r;
    end
    if (img_h_r == '0) begin
      h = wmf_pkg::IMG_H_W'(1);
    end else if (img_h_r > wmf_pkg::IMG_H_W'(wmf_pkg::MAX_HEIGHT)) begin
      h = wmf_pkg::IMG_H_W'(wmf_pkg::MAX_HEIGHT);
    end else begin
      h = img_h_r;
    end
    hx = (win_w_r[2:1] > 2'(HM)) ? wmf_pkg::HALF_W'(HM) : wmf_pkg::HALF_W'(win_w_r[2:1]);
    hy = (win_h_r[2:1] > 2'(HM)) ? wmf_pkg::HALF_W'(HM) : wmf_pkg::HALF_W'(win_h_r[2:1]);
    d  = wmf_pkg::PEND_W'(hy) * wmf_pkg::PEND_W'(w) + wmf_pkg::PEND_W'(hx);
  end

  assign pixel = !func;
  assign emit  = pixel ? ((pending_r + 1'b1) > d) : (pending_r != '0);

  // window addressing for the output position
  always_comb begin
    logic [3:0] t;
    logic [3:0] rt;
    logic [3:0] u;
    col_addr = '0;
    colmask  = '0;
    rowmask  = '0;
    for (int m = 0; m < MW; m++) begin
      t = 4'(m) + 4'(MW + HM) - 4'(out_m_r);
      if (t >= 4'(2 * MW)) begin
        t = t - 4'(2 * MW);
      end else if (t >= 4'(MW)) begin
        t = t - 4'(MW);
      end
      colmask[m] = (t + 4'(hx) >= 4'(HM)) && (t <= 4'(HM) + 4'(hx));
      rt = t + 4'(out_m_r);
      if (rt < 4'(HM)) begin
        col_addr[m] = out_q_r - 1'b1;
      end else if (rt >= 4'(MW + HM)) begin
        col_addr[m] = out_q_r + 1'b1;
      end else begin
        col_addr[m] = out_q_r;
      end
    end
    for (int s = 0; s < MW; s++) begin
      u = 4'(s) + 4'(MW) - 4'(out_slot_r);
      if (u >= 4'(MW)) begin
        u = u - 4'(MW);
      end
      rowmask[s] = (u <= 4'(hy)) || (u >= 4'(MW) - 4'(hy));
    end
  end

  assign n_win = wmf_pkg::BANK_W'({hy, 1'b1}) * wmf_pkg::BANK_W'({hx, 1'b1});

  always_comb begin
    meta.valid = acc && emit;
    for (int s = 0; s < MW; s++) begin
      for (int m = 0; m < MW; m++) begin
        meta.mask[s * MW + m] = rowmask[s] && colmask[m];
      end
    end
    meta.centre = wmf_pkg::BANK_W'(out_slot_r) * wmf_pkg::BANK_W'(MW)
                + wmf_pkg::BANK_W'(out_m_r);
    meta.target = n_win >> 1;
    meta.inwin  = (wmf_pkg::IMG_H_W'(out_row_r) >= wmf_pkg::IMG_H_W'(hy))
               && (wmf_pkg::IMG_H_W'(out_row_r) + wmf_pkg::IMG_H_W'(hy) < h)
               && (wmf_pkg::IMG_W_W'(out_col_r) >= wmf_pkg::IMG_W_W'(hx))
               && (wmf_pkg::IMG_W_W'(out_col_r) + wmf_pkg::IMG_W_W'(hx) < w);
    meta.last   = (wmf_pkg::IMG_H_W'(out_row_r) == h - 1'b1)
               && (wmf_pkg::IMG_W_W'(out_col_r) == w - 1'b1);
    wr.we   = acc && pixel;
    wr.bank = wmf_pkg::BANK_W'(in_slot_r) * wmf_pkg::BANK_W'(MW) + wmf_pkg::BANK_W'(in_m_r);
    wr.addr = in_q_r;
    wr.data = sample;
  end

  // position counters
  always_comb begin
    in_col_nxt   = in_col_r;
    in_q_nxt     = in_q_r;
    in_m_nxt     = in_m_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_q_nxt    = out_q_r;
    out_m_nxt    = out_m_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    pending_nxt  = pending_r;
    if (acc && pixel) begin
      if (wmf_pkg::IMG_W_W'(in_col_r) + 1'b1 >= w) begin
        in_col_nxt  = '0;
        in_q_nxt    = '0;
        in_m_nxt    = '0;
        in_slot_nxt = (in_slot_r == wmf_pkg::SLOT_W'(MW - 1)) ? '0 : in_slot_r + 1'b1;
        in_row_nxt  = (wmf_pkg::IMG_H_W'(in_row_r) + 1'b1 >= h) ? '0 : in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
        if (in_m_r == wmf_pkg::SLOT_W'(MW - 1)) begin
          in_m_nxt = '0;
          in_q_nxt = in_q_r + 1'b1;
        end else begin
          in_m_nxt = in_m_r + 1'b1;
        end
      end
    end
    if (acc && emit) begin
      if (wmf_pkg::IMG_W_W'(out_col_r) + 1'b1 >= w) begin
        out_col_nxt  = '0;
        out_q_nxt    = '0;
        out_m_nxt    = '0;
        out_slot_nxt = (out_slot_r == wmf_pkg::SLOT_W'(MW - 1)) ? '0 : out_slot_r + 1'b1;
        out_row_nxt  = (wmf_pkg::IMG_H_W'(out_row_r) + 1'b1 >= h) ? '0 : out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
        if (out_m_r == wmf_pkg::SLOT_W'(MW - 1)) begin
          out_m_nxt = '0;
          out_q_nxt = out_q_r + 1'b1;
        end else begin
          out_m_nxt = out_m_r + 1'b1;
        end
      end
    end
    if (acc) begin
      if (pixel && !emit) begin
        pending_nxt = pending_r + 1'b1;
      end else if (!pixel && emit) begin
        pending_nxt = pending_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= wmf_pkg::RST_IMAGE_WIDTH;
      img_h_r    <= wmf_pkg::RST_IMAGE_HEIGHT;
      win_w_r    <= wmf_pkg::RST_WINDOW;
      win_h_r    <= wmf_pkg::RST_WINDOW;
      in_col_r   <= '0;
      in_q_r     <= '0;
      in_m_r     <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_q_r    <= '0;
      out_m_r    <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pending_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wmf_pkg::REG_IMAGE_WIDTH:   img_w_r <= cfg_data[wmf_pkg::IMG_W_W-1:0];
        wmf_pkg::REG_IMAGE_HEIGHT:  img_h_r <= cfg_data[wmf_pkg::IMG_H_W-1:0];
        wmf_pkg::REG_WINDOW_WIDTH:  win_w_r <= cfg_data[wmf_pkg::WIN_W-1:0];
        wmf_pkg::REG_WINDOW_HEIGHT: win_h_r <= cfg_data[wmf_pkg::WIN_W-1:0];
        default: ;
      endcase
      // any register write restarts the frame
      in_col_r   <= '0;
      in_q_r     <= '0;
      in_m_r     <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_q_r    <= '0;
      out_m_r    <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pending_r  <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_q_r     <= in_q_nxt;
      in_m_r     <= in_m_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_q_r    <= out_q_nxt;
      out_m_r    <= out_m_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      pending_r  <= pending_nxt;
    end
  end

  `WMF_CHECK(a_pending_in_lag, pending_r <= d, "pending count beyond the output lag")
  `WMF_CHECK(a_cols_in_row, (wmf_pkg::IMG_W_W'(in_col_r) < w) && (wmf_pkg::IMG_W_W'(out_col_r) < w), "column past row end")

endmodule

[src/wmf_median.sv]
// Rank-based median of the gathered window (centre sample at borders): compare stage, then rank and select.
`include "window_median_filter_macros.svh"
module wmf_median (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wmf_pkg::wmf_meta_t         meta,
  input  wmf_pkg::wmf_window_t       win,
  output logic                       push,
  output logic [wmf_pkg::DATA_W-1:0] value,
  output logic                       last
);

  localparam int NB = wmf_pkg::NUM_BANKS;

  wmf_pkg::wmf_meta_t     meta_r, meta_b_r;
  logic [NB-1:0][NB-1:0]  lt_nxt, lt_r;
  wmf_pkg::wmf_window_t   vals_r;
  logic [NB-1:0]          hit;
  logic [wmf_pkg::DATA_W-1:0] sel;

  // lt[i][j]: valid element j orders before element i (index breaks ties)
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      for (int j = 0; j < NB; j++) begin
        lt_nxt[i][j] = meta_r.mask[j] && (i != j)
                     && (($signed(win[j]) < $signed(win[i]))
                         || ((win[j] == win[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r.valid   <= 1'b0;
      meta_b_r.valid <= 1'b0;
    end else begin
      meta_r.valid   <= meta.valid;
      meta_b_r.valid <= meta_r.valid;
    end
    meta_r.mask    <= meta.mask;
    meta_r.centre  <= meta.centre;
    meta_r.target  <= meta.target;
    meta_r.inwin   <= meta.inwin;
    meta_r.last    <= meta.last;
    meta_b_r.mask   <= meta_r.mask;
    meta_b_r.centre <= meta_r.centre;
    meta_b_r.target <= meta_r.target;
    meta_b_r.inwin  <= meta_r.inwin;
    meta_b_r.last   <= meta_r.last;
    lt_r   <= lt_nxt;
    vals_r <= win;
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NB; i++) begin
      hit[i] = meta_b_r.mask[i]
            && (wmf_pkg::BANK_W'($countones(lt_r[i])) == meta_b_r.target);
      if (hit[i]) begin
        sel = sel | vals_r[i];
      end
    end
  end

  assign push  = meta_b_r.valid;
  assign value = meta_b_r.inwin ? sel : vals_r[meta_b_r.centre];
  assign last  = meta_b_r.last;

  `WMF_CHECK(a_single_median, !(meta_b_r.valid && meta_b_r.inwin) || $onehot(hit), "median rank not unique")

endmodule

[src/wmf_out_fifo.sv]
// Result queue between the median pipeline and the output stream.
`include "window_median_filter_macros.svh"
module wmf_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [wmf_pkg::DATA_W-1:0] push_value,
  input  logic                       push_last,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [wmf_pkg::DATA_W-1:0] head_value,
  output logic                       head_last
);

  logic [wmf_pkg::DATA_W:0]       mem_r [wmf_pkg::FIFO_DEPTH];
  logic [wmf_pkg::FIFO_AW-1:0]    wp_r, rp_r;
  logic [wmf_pkg::FIFO_CW-1:0]    cnt_r;
  logic                           do_pop;

  assign head_valid = (cnt_r != '0);
  assign do_pop     = pop && head_valid;
  assign head_value = mem_r[rp_r][wmf_pkg::DATA_W-1:0];
  assign head_last  = mem_r[rp_r][wmf_pkg::DATA_W];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {push_last, push_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `WMF_CHECK(a_no_overflow, !(push && !do_pop && (cnt_r == wmf_pkg::FIFO_CW'(wmf_pkg::FIFO_DEPTH))), "result queue overflow")

endmodule

[src/window_median_filter.sv]
// Path: the line store read is registered, the compare stage is registered, then the result is queued and offered.
// Throughput: one input item per cycle while the credit count is below FIFO_DEPTH; results trail the pixels by
// (window_height/2)*image_width + window_width/2 items, set by the line store.
// Reset (rst_n low, synchronous): positions and lag count cleared, registers 640x480, 3x3.
// The line store keeps no reset value and needs no clearing pass.
`include "window_median_filter_macros.svh"
module window_median_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] sample
  input  logic                           in_tuser,   // [0] func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] value
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MW = wmf_pkg::MAX_WINDOW;

  wmf_pkg::wmf_wr_t       wr;
  wmf_pkg::wmf_meta_t     meta;
  wmf_pkg::wmf_col_addr_t col_addr;
  wmf_pkg::wmf_window_t   win;
  logic                       acc, push, push_last, out_xfer;
  logic [wmf_pkg::DATA_W-1:0] push_value;
  logic [wmf_pkg::FIFO_CW-1:0] occ_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (occ_r < wmf_pkg::FIFO_CW'(wmf_pkg::FIFO_DEPTH));
  assign acc       = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  wmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .func      (in_tuser),
    .sample    (in_tdata),
    .wr        (wr),
    .meta      (meta),
    .col_addr  (col_addr)
  );

  for (genvar b = 0; b < wmf_pkg::NUM_BANKS; b++) begin : g_bank
    wmf_ram u_ram (
      .clk   (clk),
      .we    (wr.we && (wr.bank == wmf_pkg::BANK_W'(b))),
      .waddr (wr.addr),
      .wdata (wr.data),
      .raddr (col_addr[b % MW]),
      .rdata (win[b])
    );
  end

  wmf_median u_median (
    .clk   (clk),
    .rst_n (rst_n),
    .meta  (meta),
    .win   (win),
    .push  (push),
    .value (push_value),
    .last  (push_last)
  );

  wmf_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_value (push_value),
    .push_last  (push_last),
    .pop        (out_tready),
    .head_valid (out_tvalid),
    .head_value (out_tdata),
    .head_last  (out_tlast)
  );

  // credit count: results in the pipeline plus those queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (meta.valid && !out_xfer) begin
      occ_r <= occ_r + 1'b1;
    end else if (!meta.valid && out_xfer) begin
      occ_r <= occ_r - 1'b1;
    end
  end

  `WMF_CHECK(a_credit_covers_queue, !out_tvalid || (occ_r != '0), "result shown without credit")

endmodule
